// ===== design/gmps_pkg.sv =====
// Shared request, result and status types for the grid maze path search unit.
`default_nettype none

package gmps_pkg;

  // Configuration register indexes.
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  // Request opcodes.
  localparam logic OP_WRITE_CELL = 1'b0;
  localparam logic OP_SEARCH     = 1'b1;

  localparam int CFG_W   = 7;
  localparam int DEPTH_W = 12;
  localparam int DEPTH_SAT = 4095;

  typedef struct packed {
    logic              opcode;
    logic [5:0]        cell_row;
    logic [5:0]        cell_col;
    logic              cell_open;
    logic signed [7:0] start_row;
    logic signed [7:0] start_col;
    logic signed [7:0] finish_row;
    logic signed [7:0] finish_col;
  } req_t;

  typedef struct packed {
    logic               is_search_result;
    logic               found;
    logic [DEPTH_W-1:0] path_depth;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
    res_t result;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/gmps_engine.sv =====
// Search engine: grid/visited memory, path stack memory and the DFS sequencer.
`default_nettype none

module gmps_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire gmps_pkg::req_t               req,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  wire logic [$clog2(MAX_COLS+1)-1:0] cols,
  output gmps_pkg::stat_t                   stat
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS+1);
  localparam int CCW   = $clog2(MAX_COLS+1);
  localparam int AW    = RW + CW;
  localparam int MEM_D = 1 << AW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int SAW   = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS+1);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VCLR  = 4'd2;
  localparam logic [3:0] S_EP    = 4'd3;
  localparam logic [3:0] S_SRD   = 4'd4;
  localparam logic [3:0] S_AT    = 4'd5;
  localparam logic [3:0] S_NB    = 4'd6;
  localparam logic [3:0] S_NBW   = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_POPW  = 4'd9;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Grid word: bit 1 is open, bit 0 is visited.
  logic [1:0]       gmem [MEM_D];
  logic             g_we;
  logic [AW-1:0]    g_waddr;
  logic [1:0]       g_wdata;
  logic [AW-1:0]    g_raddr;
  logic [1:0]       g_rdata;

  logic [AW-1:0]    smem [CELLS];
  logic             s_we;
  logic [SAW-1:0]   s_waddr;
  logic [AW-1:0]    s_wdata;
  logic [SAW-1:0]   s_raddr;
  logic [AW-1:0]    s_rdata;

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    g_rdata <= gmem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  logic [3:0]        state, state_next;
  logic [AW:0]       cnt, cnt_next;
  logic [RW-1:0]     cur_r, cur_r_next;
  logic [CW-1:0]     cur_c, cur_c_next;
  logic [1:0]        dir, dir_next;
  logic [DW-1:0]     depth, depth_next;
  gmps_pkg::req_t    ep, ep_next;
  logic              done, done_next;
  gmps_pkg::res_t    res, res_next;

  logic              nb_ok;
  logic [RW-1:0]     nb_r;
  logic [CW-1:0]     nb_c;
  logic              ep_ok;
  logic              at_finish;

  // Neighbor of the current cell in the direction under test.
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    case (dir)
      DIR_UP: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - RW'(1);
      end
      DIR_DOWN: begin
        nb_ok = ((RCW'(cur_r) + RCW'(1)) < rows);
        nb_r  = cur_r + RW'(1);
      end
      DIR_LEFT: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - CW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = ((CCW'(cur_c) + CCW'(1)) < cols);
        nb_c  = cur_c + CW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign ep_ok = !ep.start_row[7] && !ep.start_col[7] &&
                 !ep.finish_row[7] && !ep.finish_col[7] &&
                 (int'(ep.start_row) < int'(rows)) && (int'(ep.start_col) < int'(cols)) &&
                 (int'(ep.finish_row) < int'(rows)) && (int'(ep.finish_col) < int'(cols));

  assign at_finish = (cur_r == RW'(ep.finish_row)) && (cur_c == CW'(ep.finish_col));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cur_r_next = cur_r;
    cur_c_next = cur_c;
    dir_next   = dir;
    depth_next = depth;
    ep_next    = ep;
    done_next  = 1'b0;
    res_next   = res;
    g_we       = 1'b0;
    g_waddr    = {nb_r, nb_c};
    g_wdata    = 2'b11;
    g_raddr    = {nb_r, nb_c};
    s_we       = 1'b0;
    s_waddr    = depth[SAW-1:0];
    s_wdata    = {cur_r, cur_c};
    s_raddr    = depth[SAW-1:0] - SAW'(1);

    case (state)
      S_INIT: begin
        g_we    = 1'b1;
        g_waddr = cnt[AW-1:0];
        g_wdata = 2'b00;
        cnt_next = cnt + (AW+1)'(1);
        if (cnt[AW-1:0] == AW'(MEM_D-1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req.opcode == gmps_pkg::OP_WRITE_CELL) begin
            g_we    = (int'(req.cell_row) < MAX_ROWS) && (int'(req.cell_col) < MAX_COLS);
            g_waddr = {RW'(req.cell_row), CW'(req.cell_col)};
            g_wdata = {req.cell_open, 1'b0};
            done_next = 1'b1;
            res_next  = '0;
          end else begin
            ep_next    = req;
            cnt_next   = '0;
            state_next = S_VCLR;
          end
        end
      end
      S_VCLR: begin
        // Read one entry a cycle and write it back in the next cycle with visited cleared.
        g_raddr = cnt[AW-1:0];
        g_waddr = cnt[AW-1:0] - AW'(1);
        g_wdata = {g_rdata[1], 1'b0};
        g_we    = (cnt != '0);
        cnt_next = cnt + (AW+1)'(1);
        if (cnt == (AW+1)'(MEM_D)) begin
          state_next = S_EP;
        end
      end
      S_EP: begin
        cur_r_next = RW'(ep.start_row);
        cur_c_next = CW'(ep.start_col);
        depth_next = '0;
        g_raddr    = {RW'(ep.start_row), CW'(ep.start_col)};
        if (ep_ok) begin
          state_next = S_SRD;
        end else begin
          done_next  = 1'b1;
          res_next   = '{is_search_result: 1'b1, found: 1'b0, path_depth: '0};
          state_next = S_IDLE;
        end
      end
      S_SRD: begin
        if (g_rdata[1]) begin
          g_we       = 1'b1;
          g_waddr    = {cur_r, cur_c};
          state_next = S_AT;
        end else begin
          done_next  = 1'b1;
          res_next   = '{is_search_result: 1'b1, found: 1'b0, path_depth: '0};
          state_next = S_IDLE;
        end
      end
      S_AT: begin
        dir_next = DIR_UP;
        if (at_finish) begin
          done_next  = 1'b1;
          res_next.is_search_result = 1'b1;
          res_next.found            = 1'b1;
          res_next.path_depth = (int'(depth) > gmps_pkg::DEPTH_SAT) ?
                                gmps_pkg::DEPTH_W'(gmps_pkg::DEPTH_SAT) :
                                gmps_pkg::DEPTH_W'(depth);
          state_next = S_IDLE;
        end else begin
          state_next = S_NB;
        end
      end
      S_NB: begin
        // The read address is the neighbor; its word arrives in the next state.
        if (nb_ok) begin
          state_next = S_NBW;
        end else if (dir == DIR_RIGHT) begin
          state_next = S_POP;
        end else begin
          dir_next = dir + 2'd1;
        end
      end
      S_NBW: begin
        if (g_rdata[1] && !g_rdata[0]) begin
          if (int'(depth) < CELLS) begin
            s_we       = 1'b1;
            depth_next = depth + DW'(1);
          end
          g_we       = 1'b1;
          cur_r_next = nb_r;
          cur_c_next = nb_c;
          state_next = S_AT;
        end else if (dir == DIR_RIGHT) begin
          state_next = S_POP;
        end else begin
          dir_next   = dir + 2'd1;
          state_next = S_NB;
        end
      end
      S_POP: begin
        if (depth == '0) begin
          done_next  = 1'b1;
          res_next   = '{is_search_result: 1'b1, found: 1'b0, path_depth: '0};
          state_next = S_IDLE;
        end else begin
          depth_next = depth - DW'(1);
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cur_r_next = s_rdata[AW-1:CW];
        cur_c_next = s_rdata[CW-1:0];
        state_next = S_AT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      done  <= 1'b0;
      depth <= '0;
      dir   <= DIR_UP;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      depth <= depth_next;
      dir   <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_r_next;
    cur_c <= cur_c_next;
    ep    <= ep_next;
    res   <= res_next;
  end

  assign stat.busy   = (state != S_IDLE);
  assign stat.done   = done;
  assign stat.result = res;

`ifndef NO_ASSERTIONS
  a_search_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == gmps_pkg::OP_SEARCH) |=> stat.busy && !done)
    else $error("search request did not start the engine");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= CELLS)
    else $error("path stack depth above grid size");

  a_fail_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (done && !res.found) |-> res.path_depth == '0)
    else $error("failed result carries a nonzero depth");

  a_cur_in_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_AT) |-> (RCW'(cur_r) < rows) && (CCW'(cur_c) < cols))
    else $error("current cell outside the used area");
`endif

endmodule

`default_nettype wire

// ===== design/grid_maze_path_search_unit.sv =====
// Top level of the grid maze path search unit: configuration registers and engine.
`default_nettype none

// Requests are taken when start is high and busy is low; each request gives one
// result, shown for one cycle with done high, and the receiver cannot stall it.
// After reset the unit clears the grid memory with busy high. A cell write is
// acknowledged in the next cycle. A search first sweeps the visited bits clear
// through the grid memory, then runs the depth-first walk, with one grid memory
// read per neighbor probe and one path stack read for each backtrack step.
// Configuration writes take effect at once and must be made while busy is low
// and no result is pending.
module grid_maze_path_search_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire gmps_pkg::req_t                request,
  output logic                               done,
  output gmps_pkg::res_t                     result,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [gmps_pkg::CFG_W-1:0]    cfg_data
);

  localparam int RCW = $clog2(MAX_ROWS+1);
  localparam int CCW = $clog2(MAX_COLS+1);
  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [RCW-1:0]  rows_in_use, rows_in_use_next;
  logic [CCW-1:0]  cols_in_use, cols_in_use_next;
  gmps_pkg::stat_t stat;

  // A zero reads as one, and a value above the grid size reads as the grid size.
  always_comb begin
    rows_in_use_next = rows_in_use;
    cols_in_use_next = cols_in_use;
    if (cfg_we) begin
      if (cfg_index == gmps_pkg::REG_ROWS_IN_USE) begin
        if (cfg_data == '0) begin
          rows_in_use_next = RCW'(1);
        end else if (int'(cfg_data) > MAX_ROWS) begin
          rows_in_use_next = RCW'(MAX_ROWS);
        end else begin
          rows_in_use_next = RCW'(cfg_data);
        end
      end else begin
        if (cfg_data == '0) begin
          cols_in_use_next = CCW'(1);
        end else if (int'(cfg_data) > MAX_COLS) begin
          cols_in_use_next = CCW'(MAX_COLS);
        end else begin
          cols_in_use_next = CCW'(cfg_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= RCW'(ROWS_RST);
      cols_in_use <= CCW'(COLS_RST);
    end else begin
      rows_in_use <= rows_in_use_next;
      cols_in_use <= cols_in_use_next;
    end
  end

  gmps_engine #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !stat.busy),
    .req    (request),
    .rows   (rows_in_use),
    .cols   (cols_in_use),
    .stat   (stat)
  );

  assign busy   = stat.busy;
  assign done   = stat.done;
  assign result = stat.result;

endmodule

`default_nettype wire
